/* hw/rtl/integer_nth_root_floor_top_assert.svh */
// Assertion macros for the integer n-th root block.
// Used by the top level; needs clk and rst_n in the scope where it is expanded.
`ifndef INTEGER_NTH_ROOT_FLOOR_TOP_ASSERT_SVH
`define INTEGER_NTH_ROOT_FLOOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define INR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("integer nth root: same-cycle check failed");

// Next-cycle implication, checked outside of reset.
`define INR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("integer nth root: next-cycle check failed");

`endif

/* hw/rtl/inr_pkg.sv */
// Shared types, constants and the microcode program of the integer n-th root block.
// No dependencies; used by inr_seq, inr_dp and integer_nth_root_floor_top.
package inr_pkg;

  localparam int ENTRY_BITS = 24;
  localparam int DIM_BITS   = 16;
  localparam int PROD_W     = 2 * ENTRY_BITS;
  localparam int BIT_IDX_W  = (ENTRY_BITS > 1) ? $clog2(ENTRY_BITS) : 1;
  localparam int UPC_W      = 4;

  typedef logic [UPC_W-1:0] upc_t;

  // Datapath operations, one per microcode step.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_START,
    OP_MUL,
    OP_ACCUM,
    OP_TAKE,
    OP_NEXT,
    OP_OUT,
    OP_COPY
  } uop_t;

  // Jump conditions: jump to the target when true, else fall through.
  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_START,
    C_DIM_ZERO,
    C_DIM_ONE,
    C_PROD_GT,
    C_K_MORE,
    C_BIT_MORE,
    C_OUT_BUSY
  } ucond_t;

  typedef struct packed {
    uop_t   op;
    ucond_t cond;
    upc_t   target;
  } ucode_t;

  // Status flags from the datapath that the sequencer branches on.
  typedef struct packed {
    logic dim_zero;
    logic dim_one;
    logic prod_gt;
    logic k_more;
    logic bit_more;
    logic out_busy;
  } dp_stat_t;

  // Step addresses of the program.
  localparam upc_t S_IDLE   = UPC_W'(0);
  localparam upc_t S_DIM0   = UPC_W'(1);
  localparam upc_t S_DIM1   = UPC_W'(2);
  localparam upc_t S_CAND   = UPC_W'(3);
  localparam upc_t S_MUL    = UPC_W'(4);
  localparam upc_t S_TEST   = UPC_W'(5);
  localparam upc_t S_LOOP   = UPC_W'(6);
  localparam upc_t S_TAKE   = UPC_W'(7);
  localparam upc_t S_NEXT   = UPC_W'(8);
  localparam upc_t S_FIN    = UPC_W'(9);
  localparam upc_t S_RET    = UPC_W'(10);
  localparam upc_t S_COPY   = UPC_W'(11);

  // Microcode ROM: the bitwise root search with an early-exit power test.
  function automatic ucode_t ucode_rom(input upc_t addr);
    ucode_t w;
    case (addr)
      S_IDLE: w = '{op: OP_LOAD,  cond: C_NO_START, target: S_IDLE};
      S_DIM0: w = '{op: OP_NOP,   cond: C_DIM_ZERO, target: S_FIN};
      S_DIM1: w = '{op: OP_NOP,   cond: C_DIM_ONE,  target: S_COPY};
      S_CAND: w = '{op: OP_START, cond: C_NONE,     target: S_IDLE};
      S_MUL:  w = '{op: OP_MUL,   cond: C_NONE,     target: S_IDLE};
      S_TEST: w = '{op: OP_ACCUM, cond: C_PROD_GT,  target: S_NEXT};
      S_LOOP: w = '{op: OP_NOP,   cond: C_K_MORE,   target: S_MUL};
      S_TAKE: w = '{op: OP_TAKE,  cond: C_NONE,     target: S_IDLE};
      S_NEXT: w = '{op: OP_NEXT,  cond: C_BIT_MORE, target: S_CAND};
      S_FIN:  w = '{op: OP_OUT,   cond: C_OUT_BUSY, target: S_FIN};
      S_RET:  w = '{op: OP_NOP,   cond: C_ALWAYS,   target: S_IDLE};
      S_COPY: w = '{op: OP_COPY,  cond: C_ALWAYS,   target: S_FIN};
      default: w = '{op: OP_NOP,  cond: C_ALWAYS,   target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/inr_seq.sv */
// Microcode sequencer: step counter, program ROM lookup and conditional jumps.
// Depends on inr_pkg.
module inr_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  inr_pkg::dp_stat_t stat,
  output inr_pkg::uop_t     op,
  output logic              idle
);
  import inr_pkg::*;

  upc_t   upc_r;
  upc_t   upc_nxt;
  ucode_t uw;
  logic   hit;

  // Fetch the control word and resolve the branch condition.
  always_comb begin
    uw = ucode_rom(upc_r);
    case (uw.cond)
      C_NONE:     hit = 1'b0;
      C_ALWAYS:   hit = 1'b1;
      C_NO_START: hit = !in_valid;
      C_DIM_ZERO: hit = stat.dim_zero;
      C_DIM_ONE:  hit = stat.dim_one;
      C_PROD_GT:  hit = stat.prod_gt;
      C_K_MORE:   hit = stat.k_more;
      C_BIT_MORE: hit = stat.bit_more;
      C_OUT_BUSY: hit = stat.out_busy;
      default:    hit = 1'b1;
    endcase
    upc_nxt = hit ? uw.target : upc_r + UPC_W'(1);
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign op   = uw.op;
  assign idle = (upc_r == S_IDLE);

endmodule

/* hw/rtl/inr_dp.sv */
// Datapath of the root search: operand registers, one multiplier, compare and
// the output register. Depends on inr_pkg; driven by inr_seq.
module inr_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  inr_pkg::uop_t                       op,
  input  logic                                in_valid,
  input  logic [inr_pkg::ENTRY_BITS-1:0]      in_entries,
  input  logic [inr_pkg::DIM_BITS-1:0]        in_dim,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [inr_pkg::ENTRY_BITS-1:0]      out_root_value,
  output logic                                out_bad_dim,
  output inr_pkg::dp_stat_t                   stat
);
  import inr_pkg::*;

  logic [ENTRY_BITS-1:0] entries_r;
  logic [DIM_BITS-1:0]   dim_r;
  logic [ENTRY_BITS-1:0] root_r;
  logic [BIT_IDX_W-1:0]  bit_r;
  logic [ENTRY_BITS-1:0] acc_r;
  logic [DIM_BITS-1:0]   k_r;
  logic [PROD_W-1:0]     prod_r;
  logic                  bad_r;
  logic [ENTRY_BITS-1:0] out_root_r;
  logic                  out_bad_r;
  logic                  out_valid_r;

  logic [ENTRY_BITS-1:0] cand;
  logic                  cand_one;
  logic                  out_busy;
  logic                  out_load;

  // Candidate is the root so far with the current bit set.
  always_comb begin
    cand     = root_r | ({{(ENTRY_BITS-1){1'b0}}, 1'b1} << bit_r);
    cand_one = (cand == {{(ENTRY_BITS-1){1'b0}}, 1'b1});
    out_busy = out_valid_r && !out_ready;
    out_load = (op == OP_OUT) && !out_busy;
  end

  // Status for branching. A candidate of one never grows the power, so one
  // passing multiply is enough.
  always_comb begin
    stat.dim_zero = (dim_r == '0);
    stat.dim_one  = (dim_r == DIM_BITS'(1));
    stat.prod_gt  = (prod_r > {{ENTRY_BITS{1'b0}}, entries_r});
    stat.k_more   = (k_r != dim_r) && !cand_one;
    stat.bit_more = (bit_r != '0);
    stat.out_busy = out_busy;
  end

  // Operand and search registers.
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        if (in_valid) begin
          entries_r <= in_entries;
          dim_r     <= in_dim;
          root_r    <= '0;
          bit_r     <= BIT_IDX_W'(ENTRY_BITS - 1);
          bad_r     <= (in_dim == '0);
        end
      end
      OP_START: begin
        acc_r <= {{(ENTRY_BITS-1){1'b0}}, 1'b1};
        k_r   <= '0;
      end
      OP_MUL: begin
        prod_r <= acc_r * cand;
      end
      OP_ACCUM: begin
        acc_r <= prod_r[ENTRY_BITS-1:0];
        k_r   <= k_r + DIM_BITS'(1);
      end
      OP_TAKE: begin
        root_r <= cand;
      end
      OP_NEXT: begin
        bit_r <= bit_r - BIT_IDX_W'(1);
      end
      OP_COPY: begin
        root_r <= entries_r;
      end
      default: begin
      end
    endcase
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_root_r <= root_r;
      out_bad_r  <= bad_r;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_root_value = out_root_r;
  assign out_bad_dim    = out_bad_r;

endmodule

/* hw/rtl/integer_nth_root_floor_top.sv */
// Integer n-th root (floor): microcoded sequencer plus datapath.
// Depends on inr_pkg, inr_seq, inr_dp and integer_nth_root_floor_top_assert.svh.
//
// Usage: present in_entries and in_dim with in_valid; the transaction is taken
// when in_ready is high. The result, out_root_value (largest v with v to the
// power dim not above entries) and out_bad_dim (set for a zero dimension,
// with a zero root), appears with out_valid and is held until out_ready.
// One item is worked on at a time. in_ready is high only while the sequencer
// sits in its idle step outside reset; a finished result waits in the output
// register, so the next transaction can be taken while the receiver stalls.
// A zero dimension goes from the check steps straight to the output step; a
// unit dimension first copies entries as the root. Otherwise each of the 24
// root bits runs a candidate step, then a multiply, test and loop step per
// passing multiply of the power test, then a take and a next-bit step; a
// rejected candidate goes from its test step to the next-bit step. A candidate
// of at least 2 to the power k passes at most 23 / k multiplies (15 at bit 0),
// all on the one shared multiplier stepped by the microcode. in_ready returns in
// the cycle after out_valid rises; a stalled receiver stretches the final step.
// Reset: the step counter returns to idle and the output register empties.
module integer_nth_root_floor_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [inr_pkg::ENTRY_BITS-1:0] in_entries,
  input  logic [inr_pkg::DIM_BITS-1:0]   in_dim,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [inr_pkg::ENTRY_BITS-1:0] out_root_value,
  output logic                           out_bad_dim
);
  import inr_pkg::*;

  uop_t     op;
  dp_stat_t stat;
  logic     idle;

  // Program sequencer.
  inr_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .op       (op),
    .idle     (idle)
  );

  // Datapath.
  inr_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (op),
    .in_valid       (in_valid),
    .in_entries     (in_entries),
    .in_dim         (in_dim),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_root_value (out_root_value),
    .out_bad_dim    (out_bad_dim),
    .stat           (stat)
  );

  assign in_ready = idle && rst_n;

`include "integer_nth_root_floor_top_assert.svh"

  // The block is no longer ready in the cycle after it takes a transaction.
  `INR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // A zero-dimension result always carries a zero root.
  `INR_ASSERT_NOW(a_bad_root_zero, out_valid && out_bad_dim, out_root_value == '0)
  // A new result only appears while the sequencer is still returning to idle.
  `INR_ASSERT_NOW(a_result_not_idle, $rose(out_valid), !in_ready)

endmodule

/* sim/integer_nth_root_floor_checker.sv */
// Checker for the integer n-th root block: watches both channels, predicts each root
// and compares it with the returned result. Depends on inr_pkg for the field widths.
`timescale 1ns / 100ps

module integer_nth_root_floor_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [inr_pkg::ENTRY_BITS-1:0] in_entries,
  input  logic [inr_pkg::DIM_BITS-1:0]   in_dim,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [inr_pkg::ENTRY_BITS-1:0] out_root_value,
  input  logic                           out_bad_dim,
  output int                             fail_count,
  output int                             pending_roots
);

  localparam int EB = inr_pkg::ENTRY_BITS;
  localparam int DB = inr_pkg::DIM_BITS;

  // One predicted result, kept with the operands that produced it.
  typedef struct {
    logic [EB-1:0] entries;
    logic [DB-1:0] dim;
    logic [EB-1:0] root_value;
    logic          bad_dim;
  } root_result_t;

  root_result_t root_q[$];
  int           mismatches = 0;

  // True when cand to the power deg stays at or below limit. The partial power is
  // checked against limit / cand before each multiply, so it never grows past limit.
  function automatic bit power_within(input logic [63:0] cand, input logic [31:0] deg,
                                      input logic [63:0] limit);
    logic [63:0] acc;
    acc = 64'd1;
    if (cand == 64'd1) return (limit >= 64'd1);
    for (int unsigned k = 0; k < deg; k++) begin
      if (acc > limit / cand) return 1'b0;
      acc = acc * cand;
    end
    return 1'b1;
  endfunction

  // Floor of the dim-th root of entries, found one bit at a time from the top.
  function automatic root_result_t floor_root(input logic [EB-1:0] entries,
                                              input logic [DB-1:0] dim);
    root_result_t r;
    logic [63:0]  root;
    logic [63:0]  cand;
    root = 64'd0;
    r.entries = entries;
    r.dim     = dim;
    r.bad_dim = (dim == '0);
    if (dim == DB'(1)) begin
      root = 64'(entries);
    end else if (dim != '0) begin
      for (int b = EB - 1; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (power_within(cand, 32'(dim), 64'(entries))) root = cand;
      end
    end
    r.root_value = root[EB-1:0];
    return r;
  endfunction

  // Retire the result transaction first, then record the input transaction.
  always @(posedge clk) begin
    root_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (root_q.size() == 0) begin
          $error("result with no transaction pending: root_value %0d, bad_dim %0d",
                 out_root_value, out_bad_dim);
          mismatches++;
        end else begin
          want = root_q.pop_front();
          if (out_root_value !== want.root_value) begin
            $error("root_value (entries %0d, dim %0d): expected %0d, actual %0d",
                   want.entries, want.dim, want.root_value, out_root_value);
            mismatches++;
          end
          if (out_bad_dim !== want.bad_dim) begin
            $error("bad_dim (entries %0d, dim %0d): expected %0d, actual %0d",
                   want.entries, want.dim, want.bad_dim, out_bad_dim);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) root_q.push_back(floor_root(in_entries, in_dim));
    end
    fail_count    <= mismatches;
    pending_roots <= root_q.size();
  end

endmodule

/* sim/tb_top.sv */
// Top of the integer n-th root testbench: clock, reset, stimulus, receiver stalls,
// watchdog and verdict. Depends on inr_pkg, the block and integer_nth_root_floor_checker.
`timescale 1ns / 100ps

module tb_top;

  localparam int          EB             = inr_pkg::ENTRY_BITS;
  localparam int          DB             = inr_pkg::DIM_BITS;
  localparam logic [EB-1:0] ENTRY_MAX    = '1;
  localparam logic [DB-1:0] DIM_MAX      = '1;
  localparam int          RANDOM_ITEMS   = 600;
  localparam int          WATCHDOG_LIMIT = 20000;
  localparam int          DRAIN_CYCLES   = 64;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_LONG} rx_mode_t;

  logic          clk        = 1'b0;
  logic          rst_n      = 1'b0;
  logic          in_valid   = 1'b0;
  logic          in_ready;
  logic [EB-1:0] in_entries = '0;
  logic [DB-1:0] in_dim     = '0;
  logic          out_valid;
  logic          out_ready  = 1'b0;
  logic [EB-1:0] out_root_value;
  logic          out_bad_dim;

  int       fail_count;
  int       pending_roots;
  int       idle_cycles   = 0;
  int       burst_left    = 0;
  bit       steady_sender = 1'b0;
  rx_mode_t rx_mode       = RX_OPEN;
  int       rx_cycle      = 0;
  int       hold_left     = 0;

  always #1 clk = ~clk;

  integer_nth_root_floor_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_entries    (in_entries),
    .in_dim        (in_dim),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_root_value(out_root_value),
    .out_bad_dim   (out_bad_dim)
  );

  integer_nth_root_floor_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_entries    (in_entries),
    .in_dim        (in_dim),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_root_value(out_root_value),
    .out_bad_dim   (out_bad_dim),
    .fail_count    (fail_count),
    .pending_roots (pending_roots)
  );

  // Present one input transaction and hold it until it is taken. At the start of a
  // new burst the sender may first go quiet for a random gap.
  task automatic send_item(input logic [EB-1:0] e, input logic [DB-1:0] d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = steady_sender ? 0 :
            ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    in_entries <= e;
    in_dim     <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  // Largest base whose power of the given degree still fits the entry field.
  function automatic int unsigned top_base(input int unsigned d);
    case (d)
      2:       return 4095;
      3:       return 255;
      4:       return 63;
      5:       return 27;
      default: return 15;
    endcase
  endfunction

  // Receiver: the stall pattern is redrawn at random as the run goes on.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 512 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= (rx_cycle % 4 == 0);
      RX_LONG: begin
        if (hold_left != 0) begin
          hold_left <= hold_left - 1;
          out_ready <= 1'b0;
        end else begin
          hold_left <= $urandom_range(1, 60);
          out_ready <= 1'b1;
        end
      end
      default:   out_ready <= 1'b1;
    endcase
  end

  // Watchdog: a long stretch with no transaction on either channel ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned   sel;
    int unsigned   d;
    int unsigned   v;
    logic [63:0]   p;
    logic [EB-1:0] e;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: zero dimension, zero entries, unit dimension, the field
    // extremes, and roots right at and just below a perfect power.
    send_item('0, '0);
    send_item(ENTRY_MAX, '0);
    send_item('0, DB'(1));
    send_item(ENTRY_MAX, DB'(1));
    send_item(EB'(1), DB'(1));
    send_item('0, DB'(2));
    send_item(EB'(1), DB'(2));
    send_item(EB'(3), DB'(2));
    send_item(EB'(4), DB'(2));
    send_item(ENTRY_MAX, DB'(2));
    send_item(EB'(16769025), DB'(2));
    send_item(EB'(16769024), DB'(2));
    send_item(EB'(8), DB'(3));
    send_item(EB'(7), DB'(3));
    send_item(EB'(16581375), DB'(3));
    send_item(EB'(16581374), DB'(3));
    send_item(ENTRY_MAX, DB'(23));
    send_item(ENTRY_MAX, DB'(24));
    send_item(ENTRY_MAX, DIM_MAX);
    send_item(EB'(1), DIM_MAX);
    send_item('0, DIM_MAX);
    send_item(EB'(24'h800000), DB'(16'h8000));
    send_item(EB'(24'h555555), DB'(16'hAAAA));
    send_item(EB'(24'hAAAAAA), DB'(16'h5555));

    // Random part: mostly small degrees, with many entry counts placed on or next
    // to an exact power so that the last root bit is decided by a close call.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady_sender = ((n / 60) % 3 == 1);
      sel = $urandom_range(0, 99);
      if (sel < 8) d = 0;
      else if (sel < 16) d = 1;
      else if (sel < 60) d = $urandom_range(2, 6);
      else if (sel < 80) d = $urandom_range(7, 64);
      else d = $urandom() & 32'(DIM_MAX);

      sel = $urandom_range(0, 3);
      if (d >= 2 && d <= 6 && sel < 2) begin
        v = $urandom_range(2, top_base(d));
        p = 64'd1;
        repeat (d) p = p * 64'(v);
        p = p + 64'($urandom_range(0, 2)) - 64'd1;
        e = p[EB-1:0];
      end else if (sel == 2) begin
        e = EB'($urandom() >> $urandom_range(8, 31));
      end else begin
        e = EB'($urandom());
      end
      send_item(e, DB'(d));
    end
    in_valid <= 1'b0;

    // Let the checker count the last transaction, wait for every predicted result
    // to come back, then allow a short settling time.
    @(posedge clk);
    while (pending_roots != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_roots == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
